/* hdl/fcd_pkg.sv */
// shared types, command words and result codes of the framed command decoder
package fcd_pkg;

  localparam int BYTE_W   = 8;
  localparam int CHAN_W   = 3;
  localparam int VALUE_W  = 12;
  localparam int LAMP_W   = 5;
  localparam int RESULT_W = 3;

  localparam logic [BYTE_W-1:0] OPEN_MARK  = 8'h23;
  localparam logic [BYTE_W-1:0] CLOSE_MARK = 8'h2A;
  localparam logic [BYTE_W-1:0] NUL_BYTE   = 8'h00;

  localparam int WORD_COUNT = 6;
  localparam int WORD_MAX   = 15;
  localparam int EXIT_WORD  = 5;
  localparam int IDX_W      = 3;

  typedef logic [WORD_MAX*BYTE_W-1:0] word_text_t;

  localparam word_text_t WORD_TEXT [WORD_COUNT] = '{
    "#TEMP*", "#ANEMOMETER*", {"#RAIN", "_DROP*"},
    {"#SOIL", "_MOISTURE*"}, {"#UV", "_LEVEL*"}, "#EXIT*"
  };
  localparam int WORD_LEN [WORD_COUNT] = '{6, 12, 11, 15, 10, 6};

  typedef enum logic [RESULT_W-1:0] {
    RES_NONE    = 3'd0,
    RES_TEMP    = 3'd1,
    RES_WIND    = 3'd2,
    RES_RAIN    = 3'd3,
    RES_SOIL    = 3'd4,
    RES_UV      = 3'd5,
    RES_EXIT    = 3'd6,
    RES_UNKNOWN = 3'd7
  } result_t;

  typedef struct packed {
    logic             sensor_hit;
    logic             exit_hit;
    logic [IDX_W-1:0] sensor_idx;
    result_t          result;
  } match_t;

  // byte p of word w, counted from the opening mark
  function automatic logic [BYTE_W-1:0] word_byte(input int w, input int p);
    return WORD_TEXT[w][(WORD_LEN[w]-1-p)*BYTE_W +: BYTE_W];
  endfunction

  function automatic logic [LAMP_W-1:0] lamp_for(input logic [IDX_W-1:0] idx);
    return LAMP_W'(5'b10000 >> idx);
  endfunction

endpackage

/* hdl/fcd_cmd_if.sv */
// input channel: serial byte or sensor sample word
interface fcd_cmd_if;
  logic                          valid;
  logic                          ready;
  logic                          command;
  logic [fcd_pkg::BYTE_W-1:0]    serial_byte;
  logic [fcd_pkg::CHAN_W-1:0]    sample_channel;
  logic [fcd_pkg::VALUE_W-1:0]   sample_value;

  modport source(output valid, command, serial_byte, sample_channel, sample_value,
                 input ready);
  modport sink(input valid, command, serial_byte, sample_channel, sample_value,
               output ready);
endinterface

/* hdl/fcd_rsp_if.sv */
// result channel: reply, lamps and frame result word
interface fcd_rsp_if;
  logic                          valid;
  logic                          ready;
  logic                          reply_valid;
  logic [fcd_pkg::VALUE_W-1:0]   reply_value;
  logic [fcd_pkg::LAMP_W-1:0]    lamp_pattern;
  logic [fcd_pkg::RESULT_W-1:0]  frame_result;

  modport source(output valid, reply_valid, reply_value, lamp_pattern, frame_result,
                 input ready);
  modport sink(input valid, reply_valid, reply_value, lamp_pattern, frame_result,
               output ready);
endinterface

/* hdl/fcd_sample_store.sv */
// stored sensor readings, one register per channel
module fcd_sample_store #(
  parameter int SAMPLE_BITS     = 12,
  parameter int SENSOR_CHANNELS = 8,
  parameter int CH_W            = $clog2(SENSOR_CHANNELS)
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   wr_en,
  input  logic [CH_W-1:0]        wr_idx,
  input  logic [SAMPLE_BITS-1:0] wr_data,
  input  logic [CH_W-1:0]        rd_idx,
  output logic [SAMPLE_BITS-1:0] rd_data
);

  logic [SAMPLE_BITS-1:0] sample_store [SENSOR_CHANNELS];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SENSOR_CHANNELS; i++) sample_store[i] <= '0;
    end else if (wr_en) begin
      sample_store[wr_idx] <= wr_data;
    end
  end

  always_comb begin
    rd_data = '0;
    for (int i = 0; i < SENSOR_CHANNELS; i++) begin
      if (rd_idx == CH_W'(i)) rd_data = sample_store[i];
    end
  end

endmodule

/* hdl/fcd_frame_matcher.sv */
// frame tracking with running per-word match flags
module fcd_frame_matcher #(
  parameter int FRAME_BYTES = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       step,
  input  logic [fcd_pkg::BYTE_W-1:0] rx_byte,
  output fcd_pkg::match_t            match
);
  import fcd_pkg::*;

  localparam int LEN_W = $clog2(FRAME_BYTES + 1);

  logic [LEN_W-1:0]      frame_length, frame_length_next;
  logic                  frame_overflowed, frame_overflowed_next;
  logic [WORD_COUNT-1:0] word_live, word_live_next;
  logic [WORD_COUNT-1:0] byte_ok, final_pos, hit;
  logic                  fits;

  assign fits = frame_length < LEN_W'(FRAME_BYTES);

  always_comb begin
    for (int w = 0; w < WORD_COUNT; w++) begin
      byte_ok[w] = 1'b0;
      for (int q = 0; q < WORD_MAX; q++) begin
        if (q < WORD_LEN[w] && frame_length == LEN_W'(q) && rx_byte == word_byte(w, q))
          byte_ok[w] = 1'b1;
      end
      final_pos[w] = frame_length == LEN_W'(WORD_LEN[w] - 1);
      hit[w]       = word_live[w] && final_pos[w] && fits && !frame_overflowed;
    end
  end

  always_comb begin
    match                 = '0;
    match.result          = RES_NONE;
    frame_length_next     = frame_length;
    frame_overflowed_next = frame_overflowed;
    word_live_next        = word_live;
    if (rx_byte == OPEN_MARK) begin
      frame_length_next     = LEN_W'(1);
      frame_overflowed_next = 1'b0;
      word_live_next        = '1;
    end else if (rx_byte == CLOSE_MARK) begin
      match.result = RES_UNKNOWN;
      // lowest word wins
      for (int w = WORD_COUNT - 1; w >= 0; w--) begin
        if (hit[w]) begin
          if (w == EXIT_WORD) begin
            match.exit_hit   = 1'b1;
            match.sensor_hit = 1'b0;
            match.result     = RES_EXIT;
          end else begin
            match.exit_hit   = 1'b0;
            match.sensor_hit = 1'b1;
            match.sensor_idx = IDX_W'(w);
            match.result     = result_t'(RESULT_W'(w + 1));
          end
        end
      end
      frame_length_next     = '0;
      frame_overflowed_next = 1'b0;
    end else if (rx_byte != NUL_BYTE && frame_length != '0) begin
      if (fits) begin
        frame_length_next = frame_length + LEN_W'(1);
        word_live_next    = word_live & byte_ok;
      end else begin
        frame_overflowed_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_length     <= '0;
      frame_overflowed <= 1'b0;
      word_live        <= '0;
    end else if (step) begin
      frame_length     <= frame_length_next;
      frame_overflowed <= frame_overflowed_next;
      word_live        <= word_live_next;
    end
  end

endmodule

/* hdl/framed_command_decoder_unit.sv */
// top level of the framed command decoder
// the input register and the result register lie between an accepted input word and its result word
// throughput: one word per cycle, all work done in one short stage between the two registers
// the result register stalls only while its word is not taken; the input register then holds
// synchronous active-high reset clears readings, lamps, frame state and both valid flags
module framed_command_decoder_unit #(
  parameter int FRAME_BYTES     = 16,
  parameter int SAMPLE_BITS     = 12,
  parameter int SENSOR_CHANNELS = 8
) (
  input  logic     clk,
  input  logic     rst,
  fcd_cmd_if.sink  cmd_ch,
  fcd_rsp_if.source rsp_ch
);
  import fcd_pkg::*;

  localparam int CH_W = $clog2(SENSOR_CHANNELS);

  logic                s1_valid;
  logic                s1_command;
  logic [BYTE_W-1:0]   s1_byte;
  logic [CHAN_W-1:0]   s1_channel;
  logic [VALUE_W-1:0]  s1_value;
  logic                s1_go;

  logic                o_valid;
  logic                o_reply_valid;
  logic [VALUE_W-1:0]  o_reply_value;
  logic [LAMP_W-1:0]   o_lamp;
  result_t             o_result;

  logic [LAMP_W-1:0]   lamp_state, lamp_state_next;
  logic                reply_valid_next;
  logic [VALUE_W-1:0]  reply_value_next;
  result_t             result_next;

  match_t                 match;
  logic [SAMPLE_BITS-1:0] rd_data;
  logic                   sample_wr;

  assign s1_go        = s1_valid && (!o_valid || rsp_ch.ready);
  assign cmd_ch.ready = !s1_valid || s1_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (cmd_ch.ready) begin
      s1_valid <= cmd_ch.valid;
    end
    if (cmd_ch.valid && cmd_ch.ready) begin
      s1_command <= cmd_ch.command;
      s1_byte    <= cmd_ch.serial_byte;
      s1_channel <= cmd_ch.sample_channel;
      s1_value   <= cmd_ch.sample_value;
    end
  end

  assign sample_wr = s1_go && s1_command && (32'(s1_channel) < SENSOR_CHANNELS);

  fcd_sample_store #(
    .SAMPLE_BITS    (SAMPLE_BITS),
    .SENSOR_CHANNELS(SENSOR_CHANNELS),
    .CH_W           (CH_W)
  ) u_store (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (sample_wr),
    .wr_idx (CH_W'(s1_channel)),
    .wr_data(SAMPLE_BITS'(s1_value)),
    .rd_idx (CH_W'(match.sensor_idx)),
    .rd_data(rd_data)
  );

  fcd_frame_matcher #(
    .FRAME_BYTES(FRAME_BYTES)
  ) u_matcher (
    .clk    (clk),
    .rst    (rst),
    .step   (s1_go && !s1_command),
    .rx_byte(s1_byte),
    .match  (match)
  );

  always_comb begin
    lamp_state_next  = lamp_state;
    reply_valid_next = 1'b0;
    reply_value_next = '0;
    result_next      = RES_NONE;
    if (!s1_command) begin
      result_next = match.result;
      if (match.sensor_hit) begin
        lamp_state_next  = lamp_for(match.sensor_idx);
        reply_valid_next = 1'b1;
        reply_value_next = VALUE_W'(rd_data);
      end else if (match.exit_hit) begin
        lamp_state_next = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lamp_state <= '0;
      o_valid    <= 1'b0;
    end else begin
      if (s1_go) lamp_state <= lamp_state_next;
      if (s1_go) begin
        o_valid <= 1'b1;
      end else if (rsp_ch.ready) begin
        o_valid <= 1'b0;
      end
    end
    if (s1_go) begin
      o_reply_valid <= reply_valid_next;
      o_reply_value <= reply_value_next;
      o_lamp        <= lamp_state_next;
      o_result      <= result_next;
    end
  end

  assign rsp_ch.valid        = o_valid;
  assign rsp_ch.reply_valid  = o_reply_valid;
  assign rsp_ch.reply_value  = o_reply_value;
  assign rsp_ch.lamp_pattern = o_lamp;
  assign rsp_ch.frame_result = o_result;

  a_reply_one_lamp: assert property (@(posedge clk) disable iff (rst)
    o_valid && o_reply_valid |-> $onehot(o_lamp))
    else $error("reply without a single lamp");

  a_exit_dark: assert property (@(posedge clk) disable iff (rst)
    o_valid && o_result == RES_EXIT |-> o_lamp == '0 && !o_reply_valid)
    else $error("exit word left lamps on or replied");

  a_no_reply_zero: assert property (@(posedge clk) disable iff (rst)
    o_valid && !o_reply_valid |-> o_reply_value == '0)
    else $error("reply value without reply");

  a_stall_holds_input: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_go |=> s1_valid && $stable(s1_byte) && $stable(s1_command))
    else $error("held input word lost");

  a_sample_no_result: assert property (@(posedge clk) disable iff (rst)
    s1_go && s1_command |=> o_result == RES_NONE && !o_reply_valid)
    else $error("sample word produced a frame result");

endmodule

/* tb/framed_command_decoder_unit_test.sv */
`timescale 1ns / 1ps
// self-checking testbench of the framed command decoder unit with its own decode predictor
module framed_command_decoder_unit_test;
  import fcd_pkg::*;

  localparam int FRAME_DEPTH = 16;
  localparam int CHANNELS    = 8;
  localparam int RANDOM_WORDS = 1800;
  localparam int STALL_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 8;
  localparam int REPORT_MAX  = 10;

  typedef struct {
    logic               command;
    logic [BYTE_W-1:0]  serial_byte;
    logic [CHAN_W-1:0]  sample_channel;
    logic [VALUE_W-1:0] sample_value;
    int                 gap;
    bit                 drain;
  } cmd_word_t;

  typedef struct packed {
    logic               reply_valid;
    logic [VALUE_W-1:0] reply_value;
    logic [LAMP_W-1:0]  lamp_pattern;
    result_t            frame_result;
  } reply_t;

  logic clk;
  logic rst;

  fcd_cmd_if cmd_ch ();
  fcd_rsp_if rsp_ch ();

  framed_command_decoder_unit dut (
    .clk(clk),
    .rst(rst),
    .cmd_ch(cmd_ch),
    .rsp_ch(rsp_ch)
  );

  string cmd_words [WORD_COUNT] = '{
    "#TEMP*", "#ANEMOMETER*", string'({"#RAIN", "_DROP*"}),
    string'({"#SOIL", "_MOISTURE*"}), string'({"#UV", "_LEVEL*"}), "#EXIT*"
  };

  // predictor state
  logic [VALUE_W-1:0] readings [CHANNELS];
  logic [BYTE_W-1:0]  frame_buf [FRAME_DEPTH];
  int                 frame_len;
  bit                 frame_bad;
  logic [LAMP_W-1:0]  lamps;

  cmd_word_t words_to_send [$];
  reply_t    replies_due [$];

  bit steady_seq;
  bit drain_next;
  bit word_taken;
  bit lead_loaded;
  int lead_left;
  int stall_left;
  int calm_left;
  int hold_phase;
  int idle_cycles;
  int words_in;
  int results_seen;
  int faults;
  int tally [8];

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic void frame_push(input logic [BYTE_W-1:0] b);
    if (frame_len < FRAME_DEPTH) begin
      frame_buf[frame_len] = b;
      frame_len++;
    end else begin
      frame_bad = 1'b1;
    end
  endfunction

  function automatic reply_t decode_word(input logic command, input logic [BYTE_W-1:0] b,
                                         input logic [CHAN_W-1:0] ch,
                                         input logic [VALUE_W-1:0] v);
    reply_t r;
    int     hit;
    bit     same;
    r.reply_valid  = 1'b0;
    r.reply_value  = '0;
    r.frame_result = RES_NONE;
    if (command) begin
      readings[ch] = v;
    end else if (b == OPEN_MARK) begin
      frame_len = 0;
      frame_bad = 1'b0;
      frame_push(b);
    end else if (b == CLOSE_MARK) begin
      frame_push(b);
      r.frame_result = RES_UNKNOWN;
      if (!frame_bad) begin
        hit = -1;
        for (int w = 0; w < WORD_COUNT; w++) begin
          if (hit < 0 && cmd_words[w].len() == frame_len) begin
            same = 1'b1;
            for (int p = 0; p < frame_len; p++)
              if (frame_buf[p] != cmd_words[w][p]) same = 1'b0;
            if (same) hit = w;
          end
        end
        if (hit == EXIT_WORD) begin
          lamps = '0;
          r.frame_result = RES_EXIT;
        end else if (hit >= 0) begin
          lamps = LAMP_W'(5'b10000 >> hit);
          r.reply_valid  = 1'b1;
          r.reply_value  = readings[hit];
          r.frame_result = result_t'(hit + 1);
        end
      end
      frame_len = 0;
      frame_bad = 1'b0;
    end else if (b != NUL_BYTE && frame_len != 0) begin
      frame_push(b);
    end
    r.lamp_pattern = lamps;
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    if (steady_seq) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  function automatic logic [BYTE_W-1:0] plain_byte();
    logic [BYTE_W-1:0] b;
    do b = BYTE_W'($urandom_range(1, 255));
    while (b == OPEN_MARK || b == CLOSE_MARK);
    return b;
  endfunction

  task automatic queue_word(input logic command, input logic [BYTE_W-1:0] b,
                            input logic [CHAN_W-1:0] ch, input logic [VALUE_W-1:0] v);
    cmd_word_t w;
    w.command        = command;
    w.serial_byte    = b;
    w.sample_channel = ch;
    w.sample_value   = v;
    w.gap            = pick_gap();
    w.drain          = drain_next;
    drain_next       = 1'b0;
    words_to_send.push_back(w);
  endtask

  task automatic queue_byte(input logic [BYTE_W-1:0] b);
    queue_word(1'b0, b, CHAN_W'($urandom), VALUE_W'($urandom));
  endtask

  task automatic queue_sample(input logic [CHAN_W-1:0] ch, input logic [VALUE_W-1:0] v);
    queue_word(1'b1, BYTE_W'($urandom), ch, v);
  endtask

  task automatic queue_text(input string s, input int count);
    for (int i = 0; i < count; i++) queue_byte(s[i]);
  endtask

  task automatic build_stimulus();
    int counted;
    int next_drain;
    int r;
    int w;
    int k;
    int n;
    string txt;
    logic [BYTE_W-1:0] other;
    logic [VALUE_W-1:0] v;

    // extremes, ignored bytes, stray close, re-open and a broken-up word
    queue_sample(3'd0, 12'hFFF);
    queue_sample(3'd7, 12'h000);
    queue_sample(3'd4, 12'hABC);
    queue_byte(NUL_BYTE);
    queue_byte(8'h41);
    queue_byte(CLOSE_MARK);
    queue_byte(8'hFF);
    queue_text("#TE", 3);
    queue_byte(NUL_BYTE);
    queue_text("MP*", 3);
    queue_text("#X#EXIT*", 8);

    drain_next = 1'b1;
    next_drain = 450;
    counted = 0;
    while (counted < RANDOM_WORDS) begin
      steady_seq = ($urandom_range(0, 3) == 0);
      if (counted >= next_drain) begin
        drain_next = 1'b1;
        next_drain += 450;
      end
      r = $urandom_range(0, 99);
      w = $urandom_range(0, WORD_COUNT - 1);
      txt = cmd_words[w];
      if (r < 18) begin
        n = $urandom_range(1, 4);
        repeat (n) begin
          k = $urandom_range(0, 9);
          v = (k == 0) ? '0 : (k == 1) ? '1 : VALUE_W'($urandom);
          queue_sample(CHAN_W'($urandom), v);
        end
        counted += n;
      end else if (r < 60) begin
        if ($urandom_range(0, 4) == 0) queue_byte(plain_byte());
        for (int i = 0; i < txt.len(); i++) begin
          if (i > 0 && $urandom_range(0, 19) == 0) queue_byte(NUL_BYTE);
          queue_byte(txt[i]);
        end
        counted += txt.len();
      end else if (r < 72) begin
        k = $urandom_range(1, txt.len() - 2);
        do other = plain_byte();
        while (other == txt[k]);
        for (int i = 0; i < txt.len(); i++) queue_byte((i == k) ? other : txt[i]);
        counted += txt.len();
      end else if (r < 78) begin
        k = $urandom_range(1, txt.len() - 2);
        queue_text(txt, k);
        queue_byte(CLOSE_MARK);
        counted += k + 1;
      end else if (r < 84) begin
        k = $urandom_range(1, txt.len() - 1);
        queue_text(txt, k);
        txt = cmd_words[$urandom_range(0, WORD_COUNT - 1)];
        queue_text(txt, txt.len());
        counted += k + txt.len();
      end else if (r < 93) begin
        // runs past the frame store from fifteen filler bytes on
        n = $urandom_range(12, 20);
        queue_byte(OPEN_MARK);
        repeat (n) queue_byte(plain_byte());
        queue_byte(CLOSE_MARK);
        counted += n + 2;
      end else begin
        repeat ($urandom_range(1, 6)) queue_byte(BYTE_W'($urandom_range(0, 255)));
      end
    end
  endtask

  // sender
  always @(negedge clk) begin
    if (!rst && (word_taken || !cmd_ch.valid)) begin
      if (word_taken) begin
        void'(words_to_send.pop_front());
        word_taken  = 1'b0;
        lead_loaded = 1'b0;
      end
      if (words_to_send.size() == 0) begin
        cmd_ch.valid <= 1'b0;
      end else begin
        if (!lead_loaded) begin
          lead_left   = words_to_send[0].gap;
          lead_loaded = 1'b1;
        end
        if (lead_left > 0) begin
          lead_left--;
          cmd_ch.valid <= 1'b0;
        end else if (words_to_send[0].drain && replies_due.size() != 0) begin
          cmd_ch.valid <= 1'b0;
        end else begin
          cmd_ch.valid          <= 1'b1;
          cmd_ch.command        <= words_to_send[0].command;
          cmd_ch.serial_byte    <= words_to_send[0].serial_byte;
          cmd_ch.sample_channel <= words_to_send[0].sample_channel;
          cmd_ch.sample_value   <= words_to_send[0].sample_value;
        end
      end
    end
  end

  // receiver
  always @(negedge clk) begin
    int r;
    if (!rst) begin
      if ((hold_phase == 0 && results_seen >= 300) || (hold_phase == 1 && results_seen >= 1100)) begin
        stall_left = 150;
        hold_phase++;
      end
      if (stall_left > 0) begin
        stall_left--;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= 1'b1;
        if (calm_left > 0) begin
          calm_left--;
        end else begin
          r = $urandom_range(0, 99);
          if (r < 3) calm_left = $urandom_range(20, 80);
          else if (r < 60) stall_left = 0;
          else if (r < 92) stall_left = $urandom_range(1, 3);
          else stall_left = $urandom_range(6, 40);
        end
      end
    end
  end

  // input capture, result check and watchdog
  always @(posedge clk) begin
    reply_t want;
    reply_t got;
    if (!rst) begin
      idle_cycles++;
      if (cmd_ch.valid && cmd_ch.ready) begin
        replies_due.push_back(decode_word(cmd_ch.command, cmd_ch.serial_byte,
                                          cmd_ch.sample_channel, cmd_ch.sample_value));
        word_taken = 1'b1;
        words_in++;
        idle_cycles = 0;
      end
      if (rsp_ch.valid && rsp_ch.ready) begin
        got.reply_valid  = rsp_ch.reply_valid;
        got.reply_value  = rsp_ch.reply_value;
        got.lamp_pattern = rsp_ch.lamp_pattern;
        got.frame_result = result_t'(rsp_ch.frame_result);
        results_seen++;
        idle_cycles = 0;
        if (replies_due.size() == 0) begin
          faults++;
          if (faults <= REPORT_MAX)
            $display("unexpected result word: valid %0b value %0d lamps %b result %0d",
                     got.reply_valid, got.reply_value, got.lamp_pattern, got.frame_result);
        end else begin
          want = replies_due.pop_front();
          tally[want.frame_result]++;
          if (got.reply_valid !== want.reply_valid || got.reply_value !== want.reply_value ||
              got.lamp_pattern !== want.lamp_pattern ||
              got.frame_result !== want.frame_result) begin
            faults++;
            if (faults <= REPORT_MAX) begin
              $display("mismatch at result %0d: expected valid %0b value %0d lamps %b result %0d",
                       results_seen, want.reply_valid, want.reply_value, want.lamp_pattern,
                       want.frame_result);
              $display("  got valid %0b value %0d lamps %b result %0d",
                       got.reply_valid, got.reply_value, got.lamp_pattern, got.frame_result);
            end
          end
        end
      end
      if (idle_cycles >= STALL_LIMIT) begin
        $display("watchdog: no word moved for %0d cycles", idle_cycles);
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin
    rst                   = 1'b1;
    cmd_ch.valid          = 1'b0;
    cmd_ch.command        = 1'b0;
    cmd_ch.serial_byte    = '0;
    cmd_ch.sample_channel = '0;
    cmd_ch.sample_value   = '0;
    rsp_ch.ready          = 1'b0;
    for (int c = 0; c < CHANNELS; c++) readings[c] = '0;
    for (int p = 0; p < FRAME_DEPTH; p++) frame_buf[p] = '0;
    frame_len = 0;
    frame_bad = 1'b0;
    lamps     = '0;
    build_stimulus();
    repeat (5) @(posedge clk);
    @(negedge clk) rst <= 1'b0;
    while (words_to_send.size() != 0 || replies_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    $display("%0d input words sent, %0d result words checked", words_in, results_seen);
    $display("%0d sensor replies, %0d exit frames, %0d rejected frames, %0d quiet words",
             tally[1] + tally[2] + tally[3] + tally[4] + tally[5], tally[6], tally[7], tally[0]);
    if (faults == 0 && replies_due.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d mismatches, %0d result words missing", faults, replies_due.size());
      $display("simulation failed");
    end
    $finish;
  end

endmodule

/* framed_command_decoder_unit.f */
hdl/fcd_pkg.sv
hdl/fcd_cmd_if.sv
hdl/fcd_rsp_if.sv
hdl/fcd_sample_store.sv
hdl/fcd_frame_matcher.sv
hdl/framed_command_decoder_unit.sv
tb/framed_command_decoder_unit_test.sv
